>>> rtl/request_queue_random_drop_defines.svh
// Assertion macros used by the request queue top level.
`ifndef REQUEST_QUEUE_RANDOM_DROP_DEFINES_SVH
`define REQUEST_QUEUE_RANDOM_DROP_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define RQRD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RQRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RQRD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/rqrd_pkg.sv
// Shared constants, codes and types of the request queue.
`default_nettype none
package rqrd_pkg;
	localparam int DEPTH  = 64;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CONN_W = 16;
	localparam int TIME_W = 48;
	localparam int RAND_W = 16;
	localparam int OCC_W  = 7;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DROP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RANDOM = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// Per-cell update control
	typedef struct packed {
		logic load;   // take the pushed entry
		logic shift;  // take the neighbor's entry (close a gap)
	} cell_ctl_t;
endpackage
`default_nettype wire

>>> rtl/rqrd_cell.sv
// One queue slot: holds an entry, loads a new one or takes its newer neighbor's.
`default_nettype none
module rqrd_cell (
	input  wire logic                       clk,
	input  wire rqrd_pkg::cell_ctl_t        ctl,
	input  wire logic [rqrd_pkg::CONN_W-1:0] new_conn,
	input  wire logic [rqrd_pkg::TIME_W-1:0] new_time,
	input  wire logic [rqrd_pkg::CONN_W-1:0] nbr_conn,
	input  wire logic [rqrd_pkg::TIME_W-1:0] nbr_time,
	output logic      [rqrd_pkg::CONN_W-1:0] conn,
	output logic      [rqrd_pkg::TIME_W-1:0] arr_time
);
	import rqrd_pkg::*;

	logic [CONN_W-1:0] conn_q;
	logic [TIME_W-1:0] time_q;

	// Payload only, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			conn_q <= new_conn;
			time_q <= new_time;
		end else if (ctl.shift) begin
			conn_q <= nbr_conn;
			time_q <= nbr_time;
		end
	end

	assign conn     = conn_q;
	assign arr_time = time_q;
endmodule
`default_nettype wire

>>> rtl/rqrd_divider.sv
// Serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module rqrd_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rqrd_pkg::RAND_W-1:0] dividend,
	input  wire logic [rqrd_pkg::CNT_W-1:0]  divisor,
	output logic                             done,
	output logic      [rqrd_pkg::CNT_W-1:0]  rem
);
	import rqrd_pkg::*;

	localparam int STEP_W = $clog2(RAND_W + 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RAND_W-1:0] dvd_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W-1:0]  rem_nxt;

	// Shift in next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[RAND_W-1]};
		if (trial >= {1'b0, dsr_q})
			rem_nxt = CNT_W'(trial - {1'b0, dsr_q});
		else
			rem_nxt = trial[CNT_W-1:0];
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(RAND_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[RAND_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

>>> rtl/request_queue_random_drop.sv
// Bounded request queue with push, drop-oldest and random removal.
// A command steps through the position, two selection-tree and apply states to done; a random
// removal with two or more entries first waits on the serial 16-bit remainder unit.
// busy stays high until the done cycle ends, so one command is in flight at a time.
// The result is shown for the single done cycle and the receiver cannot stall it.
// Reset clears the entry count and control; slot contents are not reset.
`default_nettype none
`include "request_queue_random_drop_defines.svh"
module request_queue_random_drop (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [rqrd_pkg::CMD_W-1:0]  cmd,
	input  wire logic [rqrd_pkg::CONN_W-1:0] conn_id,
	input  wire logic [rqrd_pkg::TIME_W-1:0] arrival_time,
	input  wire logic [rqrd_pkg::RAND_W-1:0] rand_value,
	output logic                             done,
	output logic      [rqrd_pkg::STAT_W-1:0] status,
	output logic      [rqrd_pkg::CONN_W-1:0] removed_conn,
	output logic                             oldest_valid,
	output logic      [rqrd_pkg::CONN_W-1:0] oldest_conn,
	output logic      [rqrd_pkg::TIME_W-1:0] oldest_time,
	output logic      [rqrd_pkg::OCC_W-1:0]  occupancy
);
	import rqrd_pkg::*;

	localparam int GRP  = 8;
	localparam int NGRP = (DEPTH + GRP - 1) / GRP;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_POS   = 3'd2;
	localparam logic [2:0] S_TREE1 = 3'd3;
	localparam logic [2:0] S_TREE2 = 3'd4;
	localparam logic [2:0] S_APPLY = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [CONN_W-1:0] conn_q;
	logic [TIME_W-1:0] time_q;
	logic [CNT_W-1:0]  idx_q;
	logic [IDX_W-1:0]  pos_q;
	logic [CONN_W-1:0] grp_q [NGRP];
	logic [CONN_W-1:0] removed_q;
	logic [STAT_W-1:0] status_q;

	logic              accept;
	logic              div_start;
	logic              div_done;
	logic [CNT_W-1:0]  div_rem;
	logic [CNT_W-1:0]  pos_full;
	logic              q_empty;
	logic              q_full;
	logic              push_en;
	logic              rm_en;
	logic [CONN_W-1:0] grp_or;
	logic [CONN_W-1:0] grp_d [NGRP];

	cell_ctl_t         ctl      [DEPTH];
	logic [CONN_W-1:0] cell_conn[DEPTH];
	logic [TIME_W-1:0] cell_time[DEPTH];
	logic [CONN_W-1:0] sel_conn [NGRP*GRP];

	assign accept    = start && !busy;
	assign q_empty   = (count_q == '0);
	assign q_full    = (count_q == CNT_W'(DEPTH));
	assign div_start = accept && (cmd == CMD_RANDOM) && (count_q > CNT_W'(1));
	// Drop-oldest closes the gap at slot 0; random removal counts back from the newest
	assign pos_full  = (q_empty || cmd_q == CMD_DROP) ? '0 :
	                   CNT_W'(count_q - CNT_W'(1) - idx_q);

	// Queue updates happen in the apply cycle only
	assign push_en = (state_q == S_APPLY) && (cmd_q == CMD_PUSH) && !q_full;
	assign rm_en   = (state_q == S_APPLY) && !q_empty &&
	                 ((cmd_q == CMD_DROP) || (cmd_q == CMD_RANDOM));

	rqrd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rand_value),
		.divisor  (CNT_W'(count_q - CNT_W'(1))),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Row of slots, slot 0 oldest; each takes from its newer neighbor on removal
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctl[i].load  = push_en && (count_q == CNT_W'(i));
		assign ctl[i].shift = rm_en && (pos_q <= IDX_W'(i)) && (i < DEPTH - 1);
		if (i < DEPTH - 1) begin : g_mid
			rqrd_cell u_cell (
				.clk      (clk),
				.ctl      (ctl[i]),
				.new_conn (conn_q),
				.new_time (time_q),
				.nbr_conn (cell_conn[i+1]),
				.nbr_time (cell_time[i+1]),
				.conn     (cell_conn[i]),
				.arr_time (cell_time[i])
			);
		end else begin : g_last
			rqrd_cell u_cell (
				.clk      (clk),
				.ctl      (ctl[i]),
				.new_conn (conn_q),
				.new_time (time_q),
				.nbr_conn (cell_conn[i]),
				.nbr_time (cell_time[i]),
				.conn     (cell_conn[i]),
				.arr_time (cell_time[i])
			);
		end
		assign sel_conn[i] = (pos_q == IDX_W'(i)) ? cell_conn[i] : '0;
	end
	for (genvar i = DEPTH; i < NGRP*GRP; i++) begin : g_pad
		assign sel_conn[i] = '0;
	end

	// Final level of the selection tree
	always_comb begin
		grp_or = '0;
		for (int g = 0; g < NGRP; g++)
			grp_or = grp_or | grp_q[g];
	end

	// One OR per group of slots
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++)
				grp_d[g] = grp_d[g] | sel_conn[g*GRP+k];
		end
	end

	// First level of the selection tree
	always_ff @(posedge clk) begin
		if (state_q == S_TREE1) begin
			for (int g = 0; g < NGRP; g++)
				grp_q[g] <= grp_d[g];
		end
	end

	// Command capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			conn_q <= conn_id;
			time_q <= arrival_time;
		end
		if (state_q == S_POS)
			pos_q <= pos_full[IDX_W-1:0];
		if (state_q == S_TREE2)
			removed_q <= (cmd_q == CMD_RANDOM && !q_empty) ? grp_or : '0;
		if (state_q == S_APPLY) begin
			if (cmd_q == CMD_PUSH && q_full)
				status_q <= ST_FULL;
			else if ((cmd_q == CMD_DROP || cmd_q == CMD_RANDOM) && q_empty)
				status_q <= ST_EMPTY;
			else
				status_q <= ST_DONE;
		end
	end

	// Sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= div_start ? S_DIV : S_POS;
					end
				end
				S_DIV: begin
					if (div_done) begin
						idx_q   <= div_rem;
						state_q <= S_POS;
					end
				end
				S_POS:   state_q <= S_TREE1;
				S_TREE1: state_q <= S_TREE2;
				S_TREE2: state_q <= S_APPLY;
				S_APPLY: begin
					if (push_en)
						count_q <= count_q + CNT_W'(1);
					else if (rm_en)
						count_q <= count_q - CNT_W'(1);
					state_q <= S_OUT;
				end
				S_OUT:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = (state_q == S_OUT);
	assign status       = status_q;
	assign removed_conn = removed_q;
	assign oldest_valid = !q_empty;
	assign oldest_conn  = q_empty ? '0 : cell_conn[0];
	assign oldest_time  = q_empty ? '0 : cell_time[0];
	assign occupancy    = OCC_W'(count_q);

	`RQRD_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`RQRD_ASSERT_NEXT(a_done_frees, done, !busy, "busy still high after done")
	`RQRD_ASSERT_SAME(a_full_flag, done && status == ST_FULL, q_full,
		"full flag with room left")
	`RQRD_ASSERT_SAME(a_empty_flag, done && status == ST_EMPTY, q_empty && removed_conn == '0,
		"empty flag on a non-empty queue")
endmodule
`default_nettype wire
